FILE: rtl/lldj_pkg.sv
// Package for the least loaded job dispatcher: sizes, codes, payload and control types.
package lldj_pkg;

  localparam int MAX_PRINTERS = 8;
  localparam int MAX_JOBS     = 32;

  localparam int PAGE_W = 16;
  localparam int TIME_W = 21;
  localparam int JIDX_W = 5;
  localparam int PIDX_W = 3;
  localparam int CFG_W  = 4;
  localparam int PRN_W  = (MAX_PRINTERS > 1) ? $clog2(MAX_PRINTERS) : 1;
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_ASSIGN = 2'd0,
    KIND_TOTAL  = 2'd1,
    KIND_DRAIN  = 2'd2,
    KIND_REFUSE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ASSIGN,
    S_REFUSE,
    S_TOTAL,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_count;
    logic              final_job;
  } in_t;

  typedef struct packed {
    kind_t             result_kind;
    logic [PIDX_W-1:0] printer_index;
    logic [JIDX_W-1:0] job_index;
    logic [PAGE_W-1:0] job_pages;
    logic [TIME_W-1:0] time_value;
    logic              end_of_run;
  } out_t;

  // running minimum handed down the printer chain
  typedef struct packed {
    logic [TIME_W-1:0] load;
    logic [PRN_W-1:0]  idx;
  } cand_t;

  typedef struct packed {
    logic              scan;
    logic [PRN_W-1:0]  pos;
    logic              upd;
    logic [PRN_W-1:0]  sel;
    logic [TIME_W-1:0] wdata;
    logic              clr;
  } prn_ctl_t;

  typedef struct packed {
    logic [PAGE_W-1:0] pages;
    logic [TIME_W-1:0] finish;
    logic [JIDX_W-1:0] idx;
  } job_t;

  typedef struct packed {
    logic ins;
    logic shift;
    job_t new_job;
  } job_ctl_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

endpackage

FILE: rtl/lldj_prn_cell.sv
// One printer cell: holds a load and refines the running minimum passed from its neighbor.
module lldj_prn_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lldj_pkg::prn_ctl_t        ctl,
  input  logic [lldj_pkg::PRN_W-1:0] my_idx,
  input  lldj_pkg::cand_t           cand_in,
  output lldj_pkg::cand_t           cand_out
);
  import lldj_pkg::*;

  logic [TIME_W-1:0] load_r, load_nxt;
  cand_t             cand_r, cand_nxt;

  always_comb begin
    load_nxt = load_r;
    if (ctl.clr) begin
      load_nxt = '0;
    end else if (ctl.upd && ctl.sel == my_idx) begin
      load_nxt = ctl.wdata;
    end
  end

  // strict less-than keeps the lower printer on ties
  always_comb begin
    cand_nxt = cand_r;
    if (ctl.scan && ctl.pos == my_idx) begin
      if (my_idx == '0 || load_r < cand_in.load) begin
        cand_nxt.load = load_r;
        cand_nxt.idx  = my_idx;
      end else begin
        cand_nxt = cand_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
    end else begin
      load_r <= load_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  assign cand_out = cand_r;

endmodule

FILE: rtl/lldj_job_cell.sv
// One job cell of the sorted store: insert-in-place and shift-toward-head for the drain.
module lldj_job_cell (
  input  logic               clk,
  input  lldj_pkg::job_ctl_t ctl,
  input  logic               occ,
  input  logic               prev_keep,
  input  lldj_pkg::job_t     prev_job,
  input  lldj_pkg::job_t     next_job,
  output lldj_pkg::job_t     job,
  output logic               keep
);
  import lldj_pkg::*;

  job_t job_r, job_nxt;

  // newer job wins a tie on finish time, so only a strictly later entry stays ahead
  assign keep = occ && (job_r.finish > ctl.new_job.finish);

  always_comb begin
    job_nxt = job_r;
    if (ctl.ins) begin
      if (keep) begin
        job_nxt = job_r;
      end else if (prev_keep) begin
        job_nxt = ctl.new_job;
      end else begin
        job_nxt = prev_job;
      end
    end else if (ctl.shift) begin
      job_nxt = next_job;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job = job_r;

endmodule

FILE: rtl/least_loaded_job_dispatcher_top.sv
// Top level of the least loaded job dispatcher: sequencer, printer chain and sorted job chain.
//
// Usage:
//   in_*  channel: one beat per job (page count, final flag), valid/ready.
//   out_* channel: result beats (assignment, refusal, page total, drained jobs),
//                  registered output; end_of_run marks the last beat of a job.
//   cfg_* channel: writes printer_count; always ready; write only while idle.
// Sequence:
//   A stored job is accepted in S_IDLE, then S_SCAN steps through each active printer
//   (printer_count, clamped to 1..MAX_PRINTERS) along the printer cell chain,
//   then S_ASSIGN emits the assignment and inserts the job into the sorted chain.
//   A refused job goes from S_IDLE to S_REFUSE, which emits the refusal.
//   A final job adds one beat for the total and one beat per stored job,
//   each drained from the head of the job chain.
//   Only one job is in work at a time; in_ready is high while idle, even
//   while the last result still sits in the output register.
// Reset: loads, job count and page total clear; printer_count returns to 1.
//   Job cells need no clearing, occupancy follows the job count.
// Stall: when out_ready is low the pending beat holds and the sequencer waits.
module least_loaded_job_dispatcher_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lldj_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lldj_pkg::out_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lldj_pkg::CFG_W-1:0]  cfg_data
);
  import lldj_pkg::*;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   pcount_r;
  logic [PRN_W-1:0]   pos_r, pos_nxt;
  logic [PAGE_W-1:0]  pages_r, pages_nxt;
  logic               fin_r, fin_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TIME_W-1:0]  sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  logic               in_fire, emit_ok, store_full;
  logic [PRN_W-1:0]   np_last;
  cand_t              best;
  logic [TIME_W-1:0]  fin_time;
  prn_ctl_t           prn_ctl;
  job_ctl_t           job_ctl;

  cand_t              cand   [MAX_PRINTERS];
  job_t               jobs   [MAX_JOBS];
  logic               keeps  [MAX_JOBS];

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign emit_ok    = !out_valid_r || out_ready;
  assign store_full = (count_r >= CNT_W'(MAX_JOBS));
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  // printer count clamp: zero acts as one, large values as the maximum
  always_comb begin
    if (pcount_r == '0) begin
      np_last = '0;
    end else if (32'(pcount_r) > MAX_PRINTERS) begin
      np_last = PRN_W'(MAX_PRINTERS - 1);
    end else begin
      np_last = PRN_W'(pcount_r - 4'd1);
    end
  end

  assign best     = cand[np_last];
  assign fin_time = sat_add(best.load, TIME_W'(pages_r));

  // ---------------- printer chain ----------------
  genvar gp;
  generate
    for (gp = 0; gp < MAX_PRINTERS; gp++) begin : g_prn
      cand_t cin;
      if (gp == 0) begin : g_first
        assign cin = '0;
      end else begin : g_rest
        assign cin = cand[gp-1];
      end
      lldj_prn_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (prn_ctl),
        .my_idx   (PRN_W'(gp)),
        .cand_in  (cin),
        .cand_out (cand[gp])
      );
    end
  endgenerate

  // ---------------- sorted job chain ----------------
  genvar gj;
  generate
    for (gj = 0; gj < MAX_JOBS; gj++) begin : g_job
      logic pk;
      job_t pj, nj;
      if (gj == 0) begin : g_head
        assign pk = 1'b1;
        assign pj = '0;
      end else begin : g_mid
        assign pk = keeps[gj-1];
        assign pj = jobs[gj-1];
      end
      if (gj == MAX_JOBS - 1) begin : g_tail
        assign nj = '0;
      end else begin : g_body
        assign nj = jobs[gj+1];
      end
      lldj_job_cell u_cell (
        .clk       (clk),
        .ctl       (job_ctl),
        .occ       (count_r > CNT_W'(gj)),
        .prev_keep (pk),
        .prev_job  (pj),
        .next_job  (nj),
        .job       (jobs[gj]),
        .keep      (keeps[gj])
      );
    end
  endgenerate

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = store_full ? S_REFUSE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (pos_r == np_last) begin
          state_nxt = S_ASSIGN;
        end
      end
      S_ASSIGN, S_REFUSE: begin
        if (emit_ok) begin
          state_nxt = fin_r ? S_TOTAL : S_IDLE;
        end
      end
      S_TOTAL: begin
        if (emit_ok) begin
          state_nxt = (count_r == '0) ? S_IDLE : S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (emit_ok && count_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- sequencer: datapath and outputs ----------------
  always_comb begin
    pos_nxt       = pos_r;
    pages_nxt     = pages_r;
    fin_nxt       = fin_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    prn_ctl       = '0;
    prn_ctl.pos   = pos_r;
    prn_ctl.sel   = best.idx;
    prn_ctl.wdata = fin_time;
    job_ctl               = '0;
    job_ctl.new_job.pages  = pages_r;
    job_ctl.new_job.finish = fin_time;
    job_ctl.new_job.idx    = JIDX_W'(count_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pages_nxt = in_data.page_count;
          fin_nxt   = in_data.final_job;
          pos_nxt   = '0;
        end
      end
      S_SCAN: begin
        prn_ctl.scan = 1'b1;
        pos_nxt      = pos_r + 1'b1;
      end
      S_ASSIGN: begin
        if (emit_ok) begin
          prn_ctl.upd           = 1'b1;
          job_ctl.ins           = 1'b1;
          count_nxt             = count_r + 1'b1;
          sum_nxt               = sat_add(sum_r, TIME_W'(pages_r));
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = KIND_ASSIGN;
          out_nxt.printer_index = PIDX_W'(best.idx);
          out_nxt.job_index     = JIDX_W'(count_r);
          out_nxt.job_pages     = pages_r;
          out_nxt.time_value    = fin_time;
          out_nxt.end_of_run    = !fin_r;
        end
      end
      S_REFUSE: begin
        if (emit_ok) begin
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = KIND_REFUSE;
          out_nxt.printer_index = '0;
          out_nxt.job_index     = JIDX_W'(count_r);
          out_nxt.job_pages     = pages_r;
          out_nxt.time_value    = '0;
          out_nxt.end_of_run    = !fin_r;
        end
      end
      S_TOTAL: begin
        if (emit_ok) begin
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = KIND_TOTAL;
          out_nxt.printer_index = '0;
          out_nxt.job_index     = '0;
          out_nxt.job_pages     = '0;
          out_nxt.time_value    = sum_r;
          out_nxt.end_of_run    = (count_r == '0);
          if (count_r == '0) begin
            prn_ctl.clr = 1'b1;
            sum_nxt     = '0;
          end
        end
      end
      S_DRAIN: begin
        if (emit_ok) begin
          job_ctl.shift         = 1'b1;
          count_nxt             = count_r - 1'b1;
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = KIND_DRAIN;
          out_nxt.printer_index = '0;
          out_nxt.job_index     = jobs[0].idx;
          out_nxt.job_pages     = jobs[0].pages;
          out_nxt.time_value    = jobs[0].finish;
          out_nxt.end_of_run    = (count_r == CNT_W'(1));
          if (count_r == CNT_W'(1)) begin
            prn_ctl.clr = 1'b1;
            sum_nxt     = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      pcount_r    <= CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        pcount_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    pages_r <= pages_nxt;
    fin_r   <= fin_nxt;
    out_r   <= out_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_JOBS))
    else $error("job count above store depth");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("accepted job did not start work");

  a_assign_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ASSIGN) |-> !store_full)
    else $error("assignment with full store");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && emit_ok && count_r == CNT_W'(1))
      |=> (count_r == '0 && sum_r == '0 && state_r == S_IDLE))
    else $error("drain did not empty the block");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && count_r >= CNT_W'(2)) |-> (jobs[0].finish >= jobs[1].finish))
    else $error("job chain head out of order");
`endif

endmodule

FILE: sim/tb_least_loaded_job_dispatcher_top.sv
// Testbench for the least loaded job dispatcher: directed and random batches scored against a predictor.
module tb_least_loaded_job_dispatcher_top;
  import lldj_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  // settle margin after the last beat, scaled with MAX_PRINTERS
  localparam int SETTLE_CYCLES = MAX_PRINTERS + 4;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data  = '0;

  // predictor state
  logic [TIME_W-1:0]   model_load   [MAX_PRINTERS];
  logic [PAGE_W-1:0]   model_pages  [MAX_JOBS];
  logic [TIME_W-1:0]   model_finish [MAX_JOBS];
  int                  model_job_count = 0;
  logic [TIME_W-1:0]   model_page_sum  = '0;
  logic [CFG_W-1:0]    model_prn_count = 4'd1;

  out_t                expected_beats [$];
  int                  mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  bit                  gaps_on        = 1'b1;
  int                  stall_request  = 0;

  always #5 clk = ~clk;

  least_loaded_job_dispatcher_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic logic [TIME_W-1:0] capped_sum(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
    logic [TIME_W:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    if (wide > {1'b0, TIME_MAX}) return TIME_MAX;
    return wide[TIME_W-1:0];
  endfunction

  function automatic out_t job_beat(input kind_t kind, input int prn, input int job,
                                    input logic [PAGE_W-1:0] pages,
                                    input logic [TIME_W-1:0] tval);
    out_t b;
    b.result_kind   = kind;
    b.printer_index = PIDX_W'(prn);
    b.job_index     = JIDX_W'(job);
    b.job_pages     = pages;
    b.time_value    = tval;
    b.end_of_run    = 1'b0;
    return b;
  endfunction

  // Works out every beat one job causes and queues them in order.
  task automatic predict_dispatch(input logic [PAGE_W-1:0] pages, input logic fin);
    out_t                beats [$];
    out_t                b;
    int                  active, best, p, n, i, j, pick;
    logic [TIME_W-1:0]   finish;
    bit [MAX_JOBS-1:0]   drained;
    // out of range counts clamp to 1..MAX_PRINTERS
    if (model_prn_count == 0) active = 1;
    else if (model_prn_count > MAX_PRINTERS) active = MAX_PRINTERS;
    else active = model_prn_count;

    if (model_job_count >= MAX_JOBS) begin
      // store full: refused, no load or total change
      beats.push_back(job_beat(KIND_REFUSE, 0, model_job_count, pages, '0));
    end else begin
      best = 0;
      for (p = 1; p < active; p++) begin
        if (model_load[p] < model_load[best]) best = p;
      end
      finish = capped_sum(model_load[best], {5'd0, pages});
      model_load[best] = finish;
      model_pages[model_job_count]  = pages;
      model_finish[model_job_count] = finish;
      model_page_sum = capped_sum(model_page_sum, {5'd0, pages});
      beats.push_back(job_beat(KIND_ASSIGN, best, model_job_count, pages, finish));
      model_job_count++;
    end

    if (fin) begin
      beats.push_back(job_beat(KIND_TOTAL, 0, 0, '0, model_page_sum));
      // drain order: latest finish first, later arrival wins a tie
      drained = '0;
      n = model_job_count;
      for (i = 0; i < n; i++) begin
        pick = -1;
        for (j = 0; j < n; j++) begin
          if (!drained[j]) begin
            if (pick < 0) pick = j;
            else if (model_finish[j] >= model_finish[pick]) pick = j;
          end
        end
        drained[pick] = 1'b1;
        beats.push_back(job_beat(KIND_DRAIN, 0, pick, model_pages[pick], model_finish[pick]));
      end
      for (p = 0; p < MAX_PRINTERS; p++) model_load[p] = '0;
      model_job_count = 0;
      model_page_sum  = '0;
    end

    for (i = 0; i < beats.size(); i++) begin
      b = beats[i];
      b.end_of_run = (i == beats.size() - 1);
      expected_beats.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------- channel drivers

  // One job beat; valid stays up afterwards, so back-to-back jobs keep it asserted.
  task automatic send_job(input logic [PAGE_W-1:0] pages, input logic fin);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.page_count <= pages;
    in_data.final_job  <= fin;
    do @(posedge clk); while (!in_ready);
    predict_dispatch(pages, fin);
  endtask

  // Stop offering jobs and let every expected beat come out.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_printer_count(input logic [CFG_W-1:0] value);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    model_prn_count = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PAGE_W-1:0] random_pages();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return PAGE_W'($urandom_range(0, 15));
      default: return PAGE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result side: random stall bursts, calm stretches, and long holds on request.
  initial begin : ready_driver
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!gaps_on || calm_left > 0) begin
        out_ready <= 1'b1;
        if (calm_left > 0) calm_left--;
      end else if ($urandom_range(0, 49) == 0) begin
        calm_left = $urandom_range(20, 80);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("result_kind",   want.result_kind,   out_data.result_kind);
        check_field("printer_index", want.printer_index, out_data.printer_index);
        check_field("job_index",     want.job_index,     out_data.job_index);
        check_field("job_pages",     want.job_pages,     out_data.job_pages);
        check_field("time_value",    want.time_value,    out_data.time_value);
        check_field("end_of_run",    want.end_of_run,    out_data.end_of_run);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, expected_beats.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Page extremes and bit patterns on a single printer.
  task automatic test_page_extremes();
    write_printer_count(4'd1);
    send_job(16'h0000, 1'b0);
    send_job(16'hFFFF, 1'b0);
    send_job(16'h5555, 1'b0);
    send_job(16'hAAAA, 1'b0);
    send_job(16'h0001, 1'b1);
  endtask

  // Zero printers acts as one, counts above the maximum clamp, equal loads tie low.
  task automatic test_printer_counts();
    int i;
    write_printer_count(4'd0);
    send_job(16'd7, 1'b0);
    send_job(16'd3, 1'b1);
    write_printer_count(4'd15);
    for (i = 0; i < 10; i++) send_job(16'd100, i == 9);
    write_printer_count(4'd8);
    send_job(16'd0, 1'b1);
  endtask

  // Fill the store with maximum pages, then a refused job and a refused final job.
  task automatic test_store_full();
    int i;
    write_printer_count(4'd1);
    for (i = 0; i < MAX_JOBS; i++) send_job(16'hFFFF, 1'b0);
    send_job(16'h1234, 1'b0);
    send_job(16'hFFFF, 1'b1);
  endtask

  // Long hold on the result side while jobs keep coming, so the input backs up.
  task automatic test_output_hold();
    int i;
    write_printer_count(4'd4);
    stall_request = 300;
    for (i = 0; i < 14; i++) send_job(random_pages(), i == 13);
  endtask

  // Sender pauses mid-batch until every beat so far has come out.
  task automatic test_sender_pause();
    int i;
    write_printer_count(4'd3);
    for (i = 0; i < 5; i++) send_job(random_pages(), 1'b0);
    wait_results_drained();
    for (i = 0; i < 4; i++) send_job(random_pages(), i == 3);
  endtask

  // Random batches; most end with a final job, some overrun the store.
  task automatic test_random_batches();
    int sent, batch_len, i;
    logic fin;
    sent = 0;
    while (sent < 135) begin
      if ($urandom_range(0, 2) == 0) write_printer_count(CFG_W'($urandom_range(0, 15)));
      batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 12);
      for (i = 0; i < batch_len; i++) begin
        if (i == batch_len - 1) fin = ($urandom_range(0, 9) != 0);
        else fin = ($urandom_range(0, 19) == 0);
        send_job(random_pages(), fin);
      end
      sent += batch_len;
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream();
    int i;
    write_printer_count(4'd8);
    gaps_on = 1'b0;
    for (i = 0; i < 20; i++) send_job(random_pages(), i == 19);
  endtask

  initial begin
    for (int p = 0; p < MAX_PRINTERS; p++) model_load[p] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_page_extremes();
    test_printer_counts();
    test_store_full();
    test_output_hold();
    test_sender_pause();
    test_random_batches();
    test_steady_stream();
    wait_results_drained();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
